// ----- design/safx_pkg.sv -----
package safx_pkg;

    localparam int VALUE_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUT_DATA_BITS = 80;

    localparam logic [VALUE_BITS-1:0] FULL_VALUE = 16'hFFFF;
    localparam logic [VALUE_BITS:0] ONE_P16 = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AVG_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_COEF = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PUB_SELECT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_SCALE = 3'd5;

    // publish selector codes
    localparam logic [7:0] PUB_SAMPLE = 8'd0;
    localparam logic [7:0] PUB_FILTERED = 8'd1;
    localparam logic [7:0] PUB_AVERAGE = 8'd2;
    localparam logic [7:0] PUB_MINIMUM = 8'd3;
    localparam logic [7:0] PUB_MAXIMUM = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_ADD,
        ST_DIVIDE,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_old;
        logic mul_new;
        logic add_sum;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic block_done;
        logic div_last;
        logic out_free;
        logic restart;
    } t_status;

endpackage

// ----- design/safx_ctrl.sv -----
module safx_ctrl
    import safx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD: n_state = ST_MUL_NEW;
            ST_MUL_NEW: n_state = ST_ADD;
            ST_ADD: begin
                if (i_status.block_done && !i_status.restart) begin
                    n_state = ST_DIVIDE;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_MUL_OLD: o_cmd.mul_old = 1'b1;
            ST_MUL_NEW: o_cmd.mul_new = 1'b1;
            ST_ADD:     o_cmd.add_sum = 1'b1;
            ST_DIVIDE:  o_cmd.div_step = 1'b1;
            ST_COMMIT:  o_cmd.commit = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> r_state == ST_MUL_OLD)
        else $error("accepted sample did not start the filter step");

    a_divide_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && !i_status.div_last) |=> r_state == ST_DIVIDE)
        else $error("divider left before its last step");

    a_restart_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && i_status.restart) |=> r_state == ST_COMMIT)
        else $error("restart sample went through the divider");
`endif

endmodule

// ----- design/safx_dp.sv -----
module safx_dp
    import safx_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  logic                      i_from_conv,
    input  logic                      i_restart,
    input  logic                      i_clear,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]     i_cfg_data,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [OUT_DATA_BITS-1:0]  o_out_data,
    output logic                      o_out_strobe
);

    // configuration
    logic [VALUE_BITS-1:0] r_avg_len, n_avg_len;
    logic [VALUE_BITS-1:0] r_coef, n_coef;
    logic [7:0]            r_pub_sel, n_pub_sel;
    logic                  r_log_en, n_log_en;
    logic [VALUE_BITS-1:0] r_log_period, n_log_period;
    logic [VALUE_BITS-1:0] r_full_scale, n_full_scale;

    // filter state
    logic [31:0]           r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_avg, n_avg;
    logic [VALUE_BITS-1:0] r_filt, n_filt;
    logic [VALUE_BITS-1:0] r_low, n_low;
    logic [VALUE_BITS-1:0] r_high, n_high;
    logic [VALUE_BITS-1:0] r_countdown, n_countdown;
    logic [VALUE_BITS-1:0] r_pub, n_pub;
    logic                  r_strobe, n_strobe;
    logic                  r_out_valid, n_out_valid;

    // per-sample working registers
    logic [VALUE_BITS-1:0]   r_samp;
    logic                    r_restart;
    logic                    r_clear;
    logic [31:0]             r_acc_new;
    logic [VALUE_BITS-1:0]   r_count_new;
    logic                    r_block_done;
    logic [2*VALUE_BITS+1:0] r_prod;
    logic [2*VALUE_BITS+1:0] r_fsum;
    logic [VALUE_BITS-1:0]   r_rem;
    logic [VALUE_BITS-1:0]   r_quo;
    logic [3:0]              r_div_cnt;

    logic [VALUE_BITS-1:0]   samp_ext;
    logic [VALUE_BITS-1:0]   samp_clip;
    logic [VALUE_BITS:0]     mul_a;
    logic [VALUE_BITS:0]     mul_b;
    logic [2*VALUE_BITS+1:0] prod;
    logic [VALUE_BITS:0]     shifted;
    logic [VALUE_BITS+1:0]   trial;
    logic [VALUE_BITS+1:0]   filt_shift;
    logic [VALUE_BITS-1:0]   filt_val;
    logic [VALUE_BITS-1:0]   count_inc;
    logic [VALUE_BITS-1:0]   low_base;
    logic [VALUE_BITS-1:0]   high_base;

    assign samp_ext  = VALUE_BITS'(i_sample);
    assign samp_clip = (i_from_conv && samp_ext >= r_full_scale) ? FULL_VALUE : samp_ext;
    assign count_inc = r_count + 16'd1;

    // shared multiplier: old * (k + 1), then sample * (65536 - k)
    always_comb begin
        if (i_cmd.mul_old) begin
            mul_a = {1'b0, r_filt};
            mul_b = {1'b0, r_coef} + 17'd1;
        end else begin
            mul_a = {1'b0, r_samp};
            mul_b = ONE_P16 - {1'b0, r_coef};
        end
        prod = (2*VALUE_BITS+2)'(mul_a) * (2*VALUE_BITS+2)'(mul_b);
    end

    // restoring divider step, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[VALUE_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_avg_len};

    assign filt_shift = r_fsum[2*VALUE_BITS+1:VALUE_BITS];
    assign filt_val   = (|filt_shift[VALUE_BITS+1:VALUE_BITS]) ? FULL_VALUE
                                                               : filt_shift[VALUE_BITS-1:0];

    assign low_base  = r_clear ? FULL_VALUE : r_low;
    assign high_base = r_clear ? '0 : r_high;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_samp    <= samp_clip;
            r_restart <= i_restart;
            r_clear   <= i_clear;
        end
        if (i_cmd.mul_old) begin
            r_acc_new    <= r_acc + {16'd0, r_samp};
            r_count_new  <= count_inc;
            r_block_done <= (r_avg_len != '0) && (count_inc >= r_avg_len);
        end
        if (i_cmd.mul_old || i_cmd.mul_new) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_new) begin
            r_fsum <= r_prod;
        end
        if (i_cmd.add_sum) begin
            r_fsum    <= r_fsum + r_prod;
            r_rem     <= r_acc_new[31:16];
            r_quo     <= r_acc_new[15:0];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 4'd1;
            r_quo     <= {r_quo[VALUE_BITS-2:0], ~trial[VALUE_BITS+1]};
            r_rem     <= trial[VALUE_BITS+1] ? shifted[VALUE_BITS-1:0]
                                             : trial[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        n_avg_len    = r_avg_len;
        n_coef       = r_coef;
        n_pub_sel    = r_pub_sel;
        n_log_en     = r_log_en;
        n_log_period = r_log_period;
        n_full_scale = r_full_scale;
        n_acc        = r_acc;
        n_count      = r_count;
        n_avg        = r_avg;
        n_filt       = r_filt;
        n_low        = r_low;
        n_high       = r_high;
        n_countdown  = r_countdown;
        n_pub        = r_pub;
        n_strobe     = r_strobe;
        n_out_valid  = r_out_valid && !i_out_ready;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_AVG_LENGTH: begin
                    n_avg_len = i_cfg_data;
                    n_acc     = '0;
                    n_count   = '0;
                end
                CFG_FILTER_COEF: n_coef = i_cfg_data;
                CFG_PUB_SELECT:  n_pub_sel = i_cfg_data[7:0];
                CFG_LOG_ENABLE:  n_log_en = i_cfg_data[0];
                CFG_LOG_PERIOD: begin
                    n_log_period = i_cfg_data;
                    n_countdown  = i_cfg_data;
                end
                CFG_FULL_SCALE:  n_full_scale = i_cfg_data;
                default: begin
                    n_avg_len = r_avg_len;
                end
            endcase
        end

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            n_strobe    = 1'b0;
            if (r_restart) begin
                n_avg   = r_samp;
                n_filt  = r_samp;
                n_acc   = '0;
                n_count = '0;
                n_low   = FULL_VALUE;
                n_high  = '0;
                n_pub   = r_samp;
            end else begin
                if (r_avg_len != '0) begin
                    if (r_block_done) begin
                        n_avg   = r_quo;
                        n_acc   = '0;
                        n_count = '0;
                    end else begin
                        n_acc   = r_acc_new;
                        n_count = r_count_new;
                    end
                end else begin
                    n_avg = r_samp;
                end
                n_filt = (r_coef != '0) ? filt_val : r_samp;
                n_low  = (r_samp < low_base) ? r_samp : low_base;
                n_high = (r_samp > high_base) ? r_samp : high_base;
                unique case (r_pub_sel)
                    PUB_FILTERED: n_pub = n_filt;
                    PUB_AVERAGE:  n_pub = n_avg;
                    PUB_MINIMUM:  n_pub = n_low;
                    PUB_MAXIMUM:  n_pub = n_high;
                    default:      n_pub = r_samp;
                endcase
                if (r_log_en) begin
                    if (r_countdown != '0) begin
                        n_countdown = r_countdown - 16'd1;
                    end else begin
                        n_strobe    = 1'b1;
                        n_countdown = r_log_period;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_len    <= '0;
            r_coef       <= '0;
            r_pub_sel    <= '0;
            r_log_en     <= 1'b0;
            r_log_period <= '0;
            r_full_scale <= FULL_VALUE;
            r_acc        <= '0;
            r_count      <= '0;
            r_avg        <= '0;
            r_filt       <= '0;
            r_low        <= FULL_VALUE;
            r_high       <= '0;
            r_countdown  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_avg_len    <= n_avg_len;
            r_coef       <= n_coef;
            r_pub_sel    <= n_pub_sel;
            r_log_en     <= n_log_en;
            r_log_period <= n_log_period;
            r_full_scale <= n_full_scale;
            r_acc        <= n_acc;
            r_count      <= n_count;
            r_avg        <= n_avg;
            r_filt       <= n_filt;
            r_low        <= n_low;
            r_high       <= n_high;
            r_countdown  <= n_countdown;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pub    <= n_pub;
        r_strobe <= n_strobe;
    end

    assign o_status.block_done = r_block_done;
    assign o_status.div_last   = &r_div_cnt;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.restart    = r_restart;

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = {r_high, r_low, r_filt, r_avg, r_pub};
    assign o_out_strobe = r_strobe;

`ifndef SYNTHESIS
    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low <= r_high) || (r_low == FULL_VALUE && r_high == '0))
        else $error("minimum above maximum outside the cleared state");

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_avg_len != '0) |-> (r_count < r_avg_len))
        else $error("block count reached the average length");
`endif

endmodule

// ----- design/sample_average_filter_extremes_unit.sv -----
// channel   direction  contents
// s_axis    in         tdata: sample, restart, clear_extremes; tuser: from_converter
// m_axis    out        tdata: published, average, filtered, minimum, maximum; tuser: log strobe
// i_cfg_*   in         register write: enable, index 0..5, 16-bit data
//
// the result register loads after the filter multiply and add steps; when the sample closes an
// averaging block it loads after the block divider too, which yields one quotient bit per cycle
// the filter step uses one shared 17x17 multiplier for both products, followed by an add step
// a new sample is taken once the previous result is in the output register
// a result that is not taken holds the block in its commit cycle
// synchronous active-low reset, no clearing pass after reset
module sample_average_filter_extremes_unit
    import safx_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input samples
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample, restart, clear_extremes, zero padding
    input  logic [((SAMPLE_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    // from_converter
    input  logic                      s_axis_tuser,
    // results
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // published, average_out, filtered_out, minimum_out, maximum_out
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    // log_strobe
    output logic                      m_axis_tuser,
    // register writes
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer: accept, filter multiply and add steps, optional divide, commit
    safx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // registers, accumulator, multiplier, divider and output register
    safx_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_from_conv  (s_axis_tuser),
        .i_restart    (s_axis_tdata[SAMPLE_BITS]),
        .i_clear      (s_axis_tdata[SAMPLE_BITS+1]),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_strobe (m_axis_tuser)
    );

endmodule
